// File: hw/rtl/pts_pkg.sv
// Shared types and codes for the periodic timer scheduler.
package pts_pkg;

  localparam int TIME_W   = 32;
  localparam int TAG_W    = 16;
  localparam int HANDLE_W = 4;
  localparam int COUNT_W  = 5;
  localparam int FUNC_W   = 2;
  localparam int KIND_W   = 3;

  localparam logic [TIME_W-1:0] TIME_SIGN = {1'b1, {(TIME_W-1){1'b0}}};

  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CANCEL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PROC   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_FIRED     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DONE      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REJECT    = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [TIME_W-1:0]   now;
    logic [TIME_W-1:0]   interval;
    logic [TAG_W-1:0]    user_tag;
    logic [HANDLE_W-1:0] slot;
  } req_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] handle;
    logic [TAG_W-1:0]    tag_out;
    logic [TIME_W-1:0]   fire_time;
    logic [COUNT_W-1:0]  fired_count;
    logic [TIME_W-1:0]   next_wait;
    logic                last;
  } rsp_t;

  // One timer entry as it travels around the ring.
  typedef struct packed {
    logic              armed;
    logic              done;
    logic [TIME_W-1:0] deadline;
    logic [TIME_W-1:0] period;
    logic [TAG_W-1:0]  tag;
  } entry_t;

endpackage

// File: hw/rtl/pts_cell.sv
// One ring cell: holds a timer entry and takes its neighbor's entry on each shift.
module pts_cell
  import pts_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   shift,
  input  entry_t ent_in,
  output entry_t ent
);

  logic              armed;
  logic              done;
  logic [TIME_W-1:0] deadline;
  logic [TIME_W-1:0] period;
  logic [TAG_W-1:0]  tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b0;
      done  <= 1'b0;
    end else if (shift) begin
      armed <= ent_in.armed;
      done  <= ent_in.done;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      deadline <= ent_in.deadline;
      period   <= ent_in.period;
      tag      <= ent_in.tag;
    end
  end

  assign ent = '{armed: armed, done: done, deadline: deadline, period: period, tag: tag};

endmodule

// File: hw/rtl/periodic_timer_scheduler.sv
// Periodic and one-shot timer scheduler built on a rotating ring of timer cells.
//
// Usage: requests enter on req (req_valid / req_stall) and results leave on rsp
// (rsp_valid / rsp_stall); a transfer happens at a clock edge with valid high and
// stall low. The ring holds SLOTS entries; add, cancel and process requests walk
// it in full revolutions, one cell per cycle while the ring is not paused, and the
// head cell is read and rewritten as it passes, so the slot number is the revolution
// position. Add and cancel take one revolution, then load the output register
// with their result from the emit state. A process request takes one revolution
// per fired timer plus a final one; each firing result leaves as its slot passes
// the head, then the closing result with the count and the wait to the next
// deadline. The next request is taken in the cycle after the closing result is
// loaded into the output register. An unknown request code goes straight to the
// emit state and is answered with a reject result.
// Reset (rst, synchronous) disarms every slot and idles the controller.
// A stalled receiver holds the output register; the ring pauses at a firing slot
// until the register can take the new result, so nothing is lost.
module periodic_timer_scheduler
  import pts_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int IDW = $clog2(SLOTS);
  localparam int CMPW = IDW + HANDLE_W;
  localparam logic [IDW-1:0] LAST_ID = IDW'(SLOTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state;

  // Latched request.
  logic [FUNC_W-1:0]   op;
  logic [TIME_W-1:0]   now;
  logic [TIME_W-1:0]   ival;
  logic [TAG_W-1:0]    utag;
  logic [HANDLE_W-1:0] slot;

  // Revolution bookkeeping.
  logic [IDW-1:0]     cnt;
  logic               first;
  logic               have_prev;
  logic [IDW-1:0]     prev_id;
  logic               have_pick;
  logic [IDW-1:0]     pick_id;
  logic [TIME_W-1:0]  pick_key;
  logic               have_arm;
  logic [TIME_W-1:0]  arm_key;
  logic [COUNT_W-1:0] fcount;
  logic               found;
  logic [IDW-1:0]     found_id;
  rsp_t               res;

  // Ring of cells; cell 0 is the head, the rewritten head goes to the tail.
  entry_t ring [SLOTS];
  entry_t hd;
  entry_t upd;
  logic   step;

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      entry_t nb;
      if (g == SLOTS - 1) begin : g_tail
        assign nb = upd;
      end else begin : g_mid
        assign nb = ring[g+1];
      end
      pts_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .shift  (step),
        .ent_in (nb),
        .ent    (ring[g])
      );
    end
  endgenerate

  assign hd = ring[0];

  logic              out_free;
  logic              rsp_load;
  logic              fire_here;
  logic              add_here;
  logic              cancel_here;
  logic [TIME_W-1:0] diff;
  logic [TIME_W-1:0] key;
  logic              due;
  logic              cand;
  logic              better_pick;
  logic              better_arm;
  logic              end_rev;
  logic              fin_have;
  logic [IDW-1:0]    fin_id;
  logic              fin_arm;
  logic [TIME_W-1:0] fin_arm_key;
  logic [TIME_W-1:0] fin_diff;
  logic [TIME_W-1:0] wait_ticks;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE);

  // Rewrite the head entry as it passes.
  always_comb begin
    upd         = hd;
    fire_here   = 1'b0;
    add_here    = 1'b0;
    cancel_here = 1'b0;
    if (first) begin
      upd.done = 1'b0;
    end
    if (state == ST_SCAN) begin
      priority if (op == FUNC_PROC) begin
        if (have_prev && cnt == prev_id) begin
          fire_here = 1'b1;
          upd.done  = 1'b1;
          if (hd.period == '0) begin
            upd.armed = 1'b0;
          end else begin
            upd.deadline = hd.deadline + hd.period;
          end
        end
      end else if (op == FUNC_ADD) begin
        if (!found && !hd.armed) begin
          add_here     = 1'b1;
          upd.armed    = 1'b1;
          upd.done     = 1'b0;
          upd.deadline = now + ival;
          upd.period   = ival;
          upd.tag      = utag;
        end
      end else if (op == FUNC_CANCEL) begin
        if (CMPW'(slot) == CMPW'(cnt) && hd.armed) begin
          cancel_here = 1'b1;
          upd.armed   = 1'b0;
        end
      end
    end
  end

  // Order key: signed distance to now, biased so unsigned compare orders it.
  assign diff = upd.deadline - now;
  assign key  = diff ^ TIME_SIGN;
  assign due  = (diff == '0) || diff[TIME_W-1];

  assign cand        = (op == FUNC_PROC) && upd.armed && !upd.done && due;
  assign better_pick = cand && (!have_pick || key < pick_key);
  assign better_arm  = (op == FUNC_PROC) && upd.armed && (!have_arm || key < arm_key);

  assign step    = (state == ST_SCAN) && (!fire_here || out_free);
  assign end_rev = step && (cnt == LAST_ID);

  // Load the output register with a firing or with the closing result.
  assign rsp_load = (step && fire_here) || (state == ST_EMIT && out_free);

  assign fin_have    = have_pick || better_pick;
  assign fin_id      = better_pick ? cnt : pick_id;
  assign fin_arm     = have_arm || better_arm;
  assign fin_arm_key = better_arm ? key : arm_key;
  assign fin_diff    = fin_arm_key ^ TIME_SIGN;
  assign wait_ticks  = (fin_arm && fin_diff != '0 && !fin_diff[TIME_W-1]) ? fin_diff : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      cnt       <= '0;
      first     <= 1'b0;
      have_prev <= 1'b0;
      have_pick <= 1'b0;
      have_arm  <= 1'b0;
      found     <= 1'b0;
      fcount    <= '0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            op        <= req.func;
            now       <= req.now;
            ival      <= req.interval;
            utag      <= req.user_tag;
            slot      <= req.slot;
            cnt       <= '0;
            first     <= 1'b1;
            have_prev <= 1'b0;
            have_pick <= 1'b0;
            have_arm  <= 1'b0;
            found     <= 1'b0;
            fcount    <= '0;
            if (req.func == FUNC_ADD || req.func == FUNC_CANCEL || req.func == FUNC_PROC) begin
              state <= ST_SCAN;
            end else begin
              res   <= '{kind: KIND_REJECT, last: 1'b1, default: '0};
              state <= ST_EMIT;
            end
          end
        end
        ST_SCAN: begin
          if (step) begin
            cnt <= end_rev ? '0 : cnt + 1'b1;
            // Emit a firing as its slot passes the head.
            if (fire_here) begin
              rsp       <= '{kind: KIND_FIRED, handle: HANDLE_W'(cnt), tag_out: hd.tag,
                             fire_time: hd.deadline, default: '0};
              fcount    <= fcount + 1'b1;
            end
            if (add_here || cancel_here) begin
              found    <= 1'b1;
              found_id <= cnt;
            end
            if (better_pick && !end_rev) begin
              have_pick <= 1'b1;
              pick_id   <= cnt;
              pick_key  <= key;
            end
            if (better_arm && !end_rev) begin
              have_arm <= 1'b1;
              arm_key  <= key;
            end
            if (end_rev) begin
              first <= 1'b0;
              priority if (op == FUNC_ADD) begin
                if (found || add_here) begin
                  res <= '{kind: KIND_ADDED,
                           handle: HANDLE_W'(add_here ? cnt : found_id),
                           last: 1'b1, default: '0};
                end else begin
                  res <= '{kind: KIND_REJECT, last: 1'b1, default: '0};
                end
                state <= ST_EMIT;
              end else if (op == FUNC_CANCEL) begin
                res   <= '{kind: (found || cancel_here) ? KIND_CANCELLED : KIND_REJECT,
                           handle: slot, last: 1'b1, default: '0};
                state <= ST_EMIT;
              end else if (fin_have) begin
                // Fire the chosen slot on the next revolution.
                have_prev <= 1'b1;
                prev_id   <= fin_id;
                have_pick <= 1'b0;
                have_arm  <= 1'b0;
              end else begin
                res   <= '{kind: KIND_DONE,
                           fired_count: fcount + COUNT_W'(fire_here),
                           next_wait: wait_ticks, last: 1'b1, default: '0};
                state <= ST_EMIT;
              end
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            rsp   <= res;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A transfer in always starts work.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state != ST_IDLE))
    else $error("request taken but controller stayed idle");

  // Firing results never close a request.
  a_fire_not_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.kind == KIND_FIRED) |-> !rsp.last)
    else $error("firing result marked last");

  // The ring position is at slot zero whenever no revolution runs.
  a_ring_aligned: assert property (@(posedge clk) disable iff (rst)
    (state != ST_SCAN) |-> (cnt == '0))
    else $error("ring left misaligned");

  // The ring pauses only on a firing blocked by the output register.
  a_ring_pause: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && !step) |-> (fire_here && rsp_valid && rsp_stall))
    else $error("ring stalled without cause");

endmodule
